[rtl/dsms_pkg.sv]
package dsms_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned WholeWidth = 54;
  localparam int unsigned FracWidth  = 10;
  localparam int unsigned MsWidth    = 63;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_INT   = 3'd1;
  localparam logic [2:0] PH_DOT   = 3'd2;
  localparam logic [2:0] PH_FRAC  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  localparam logic [CharWidth-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CharWidth-1:0] CHAR_CR    = 8'd13;
  localparam logic [CharWidth-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CharWidth-1:0] CHAR_DOT   = 8'd46;
  localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CharWidth-1:0] CHAR_FIVE  = 8'd53;
  localparam logic [CharWidth-1:0] CHAR_NINE  = 8'd57;

  // largest whole-seconds value that still fits in milliseconds
  localparam logic [WholeWidth-1:0] WHOLE_MAX = 54'd9223372036854775;
  // largest sub-second part allowed on top of WHOLE_MAX seconds
  localparam logic [FracWidth-1:0]  FRAC_TOP_MAX = 10'd807;

  localparam logic [WholeWidth-1:0] LIMIT_LOW  = 54'd922337203685477;
  localparam logic [WholeWidth-1:0] LIMIT_HIGH = 54'd922337203685476;

  typedef struct packed {
    logic                  bad;
    logic [WholeWidth-1:0] whole;
    logic [FracWidth-1:0]  frac;
    logic                  rnd;
  } fin_t;

  // (WHOLE_MAX - d) / 10
  function automatic logic [WholeWidth-1:0] int_limit(input logic [3:0] d);
    logic [WholeWidth-1:0] lim;
    lim = (d > 4'd5) ? LIMIT_HIGH : LIMIT_LOW;
    return lim;
  endfunction

endpackage

[rtl/dsms_if.sv]
interface dsms_in_if;
  logic                             valid;
  logic                             ready;
  logic [dsms_pkg::CharWidth-1:0]   char_code;
  logic                             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface dsms_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [dsms_pkg::MsWidth-1:0]     milliseconds;

  modport source (output valid, output status, output milliseconds, input ready);
  modport sink (input valid, input status, input milliseconds, output ready);
endinterface

[rtl/dsms_parse.sv]
module dsms_parse (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [dsms_pkg::CharWidth-1:0] char_code,
  input  logic                           last_char,
  input  logic                           fin_adv,
  output logic                           fin_valid,
  output dsms_pkg::fin_t                 fin
);

  logic [2:0]                          phase;
  logic [2:0]                          phase_next;
  logic [dsms_pkg::WholeWidth-1:0]     whole_seconds;
  logic [dsms_pkg::WholeWidth-1:0]     whole_seconds_next;
  logic [dsms_pkg::FracWidth-1:0]      fraction_ms;
  logic [dsms_pkg::FracWidth-1:0]      fraction_ms_next;
  logic [2:0]                          fraction_places;
  logic [2:0]                          fraction_places_next;
  logic                                round_bit;
  logic                                round_bit_next;
  logic                                error_flag;
  logic                                error_flag_next;

  logic                                is_space;
  logic                                is_digit;
  logic [3:0]                          digit;
  logic                                int_ok;
  logic [dsms_pkg::WholeWidth-1:0]     whole_acc;
  logic [dsms_pkg::FracWidth-1:0]      frac_acc;
  logic [dsms_pkg::FracWidth-1:0]      frac_pad;
  dsms_pkg::fin_t                      fin_next;

  assign is_space = ((char_code >= dsms_pkg::CHAR_TAB) && (char_code <= dsms_pkg::CHAR_CR)) ||
                    (char_code == dsms_pkg::CHAR_SPACE);
  assign is_digit = (char_code >= dsms_pkg::CHAR_ZERO) && (char_code <= dsms_pkg::CHAR_NINE);
  assign digit    = 4'(char_code - dsms_pkg::CHAR_ZERO);
  assign int_ok   = whole_seconds <= dsms_pkg::int_limit(digit);
  assign whole_acc = (whole_seconds << 3) + (whole_seconds << 1) +
                     dsms_pkg::WholeWidth'(digit);
  assign frac_acc  = (fraction_ms << 3) + (fraction_ms << 1) +
                     dsms_pkg::FracWidth'(digit);

  always_comb begin
    phase_next           = phase;
    whole_seconds_next   = whole_seconds;
    fraction_ms_next     = fraction_ms;
    fraction_places_next = fraction_places;
    round_bit_next       = round_bit;
    error_flag_next      = error_flag;
    if (!error_flag) begin
      case (phase)
        dsms_pkg::PH_LEAD: begin
          if (is_digit) begin
            phase_next = dsms_pkg::PH_INT;
            if (int_ok) whole_seconds_next = whole_acc;
            else error_flag_next = 1'b1;
          end else if (!is_space) begin
            error_flag_next = 1'b1;
          end
        end
        dsms_pkg::PH_INT: begin
          if (is_digit) begin
            if (int_ok) whole_seconds_next = whole_acc;
            else error_flag_next = 1'b1;
          end else if (char_code == dsms_pkg::CHAR_DOT) begin
            phase_next = dsms_pkg::PH_DOT;
          end else if (is_space) begin
            phase_next = dsms_pkg::PH_TRAIL;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        dsms_pkg::PH_DOT, dsms_pkg::PH_FRAC: begin
          if (is_digit) begin
            phase_next = dsms_pkg::PH_FRAC;
            if (fraction_places < 3'd3) fraction_ms_next = frac_acc;
            if (fraction_places == 3'd3) round_bit_next = (char_code >= dsms_pkg::CHAR_FIVE);
            if (fraction_places < 3'd4) fraction_places_next = fraction_places + 3'd1;
          end else if (is_space && (phase == dsms_pkg::PH_FRAC)) begin
            phase_next = dsms_pkg::PH_TRAIL;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        dsms_pkg::PH_TRAIL: begin
          if (!is_space) error_flag_next = 1'b1;
        end
        default: begin
          error_flag_next = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    case (fraction_places_next)
      3'd0:    frac_pad = '0;
      3'd1:    frac_pad = dsms_pkg::FracWidth'(fraction_ms_next * 7'd100);
      3'd2:    frac_pad = dsms_pkg::FracWidth'(fraction_ms_next * 4'd10);
      default: frac_pad = fraction_ms_next;
    endcase
    fin_next.bad   = error_flag_next || (phase_next == dsms_pkg::PH_LEAD) ||
                     (phase_next == dsms_pkg::PH_DOT);
    fin_next.whole = whole_seconds_next;
    fin_next.frac  = frac_pad;
    fin_next.rnd   = round_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dsms_pkg::PH_LEAD;
      whole_seconds   <= '0;
      fraction_ms     <= '0;
      fraction_places <= '0;
      round_bit       <= 1'b0;
      error_flag      <= 1'b0;
    end else if (fire) begin
      if (last_char) begin
        phase           <= dsms_pkg::PH_LEAD;
        whole_seconds   <= '0;
        fraction_ms     <= '0;
        fraction_places <= '0;
        round_bit       <= 1'b0;
        error_flag      <= 1'b0;
      end else begin
        phase           <= phase_next;
        whole_seconds   <= whole_seconds_next;
        fraction_ms     <= fraction_ms_next;
        fraction_places <= fraction_places_next;
        round_bit       <= round_bit_next;
        error_flag      <= error_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_adv) begin
      fin_valid <= fire && last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) fin <= fin_next;
  end

endmodule

[rtl/dsms_scale.sv]
module dsms_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            fin_valid,
  input  dsms_pkg::fin_t  fin,
  output logic            fin_adv,
  dsms_out_if.source      out_ch
);

  logic [dsms_pkg::MsWidth-1:0]   whole_ext;
  logic [dsms_pkg::MsWidth-1:0]   ms_sum;
  logic [dsms_pkg::FracWidth-1:0] sub_sec;
  logic                           ovf;
  logic                           bad;
  logic                           out_adv;

  assign out_adv   = !out_ch.valid || out_ch.ready;
  assign fin_adv   = !fin_valid || out_adv;

  // x1000 = x1024 - x32 + x8
  assign whole_ext = dsms_pkg::MsWidth'(fin.whole);
  assign sub_sec   = fin.frac + dsms_pkg::FracWidth'(fin.rnd);
  assign ms_sum    = (whole_ext << 10) - (whole_ext << 5) + (whole_ext << 3) +
                     dsms_pkg::MsWidth'(sub_sec);
  assign ovf       = (fin.whole == dsms_pkg::WHOLE_MAX) && (sub_sec > dsms_pkg::FRAC_TOP_MAX);
  assign bad       = fin.bad || ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_adv) begin
      out_ch.valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_ch.status       <= bad;
      out_ch.milliseconds <= bad ? '0 : ms_sum;
    end
  end

endmodule

[rtl/decimal_seconds_to_ms_parser.sv]
// Pipeline: an accepted final character moves from the input register to the
// parse stage, and its result then moves on to the output register.
// Throughput: one character per cycle; a final character stalls only while
// the parse stage and output register both hold results and ready is low.
// Reset (rst, synchronous): empties all stages and returns the parser to
// the leading whitespace phase with cleared accumulators.
module decimal_seconds_to_ms_parser (
  input  logic        clk,
  input  logic        rst,
  dsms_in_if.sink     in_ch,
  dsms_out_if.source  out_ch
);

  logic                           char_valid;
  logic [dsms_pkg::CharWidth-1:0] char_code;
  logic                           last_char;
  logic                           fire;
  logic                           fin_adv;
  logic                           fin_valid;
  dsms_pkg::fin_t                 fin;

  assign fire        = char_valid && (!last_char || fin_adv);
  assign in_ch.ready = !char_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (in_ch.ready) begin
      char_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_code <= in_ch.char_code;
      last_char <= in_ch.last_char;
    end
  end

  dsms_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_code (char_code),
    .last_char (last_char),
    .fin_adv   (fin_adv),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  dsms_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_adv   (fin_adv),
    .out_ch    (out_ch)
  );

endmodule

[test/decimal_seconds_to_ms_parser_tb.sv]
`timescale 1ns / 100ps

module decimal_seconds_to_ms_parser_tb;

  localparam longint unsigned MsMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned CharsPerPhase = 200;

  logic clk;
  logic rst;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles = 0;
  int unsigned chars_sent;
  logic [dsms_pkg::CharWidth-1:0] str[$];

  dsms_in_if in_ch ();
  dsms_out_if out_ch ();

  decimal_seconds_to_ms_parser dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  class ms_scoreboard;
    typedef struct {
      logic                         status;
      logic [dsms_pkg::MsWidth-1:0] ms;
    } ms_result_t;

    logic [2:0] phase;
    longint unsigned whole;
    int unsigned frac_ms;
    int unsigned places;
    bit rnd;
    bit err;
    ms_result_t expected_ms[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = dsms_pkg::PH_LEAD;
      whole = 0;
      frac_ms = 0;
      places = 0;
      rnd = 0;
      err = 0;
    endfunction

    function bit is_ws(logic [dsms_pkg::CharWidth-1:0] c);
      return (c >= dsms_pkg::CHAR_TAB && c <= dsms_pkg::CHAR_CR) || c == dsms_pkg::CHAR_SPACE;
    endfunction

    function bit is_digit(logic [dsms_pkg::CharWidth-1:0] c);
      return c >= dsms_pkg::CHAR_ZERO && c <= dsms_pkg::CHAR_NINE;
    endfunction

    function void add_whole_digit(int unsigned d);
      longint unsigned lim;
      lim = (MsMax / 1000 - d) / 10;
      if (whole > lim) err = 1;
      else whole = whole * 10 + d;
    endfunction

    function void add_frac_digit(logic [dsms_pkg::CharWidth-1:0] c);
      if (places < 3) frac_ms = frac_ms * 10 + (c - dsms_pkg::CHAR_ZERO);
      if (places == 3) rnd = (c >= dsms_pkg::CHAR_FIVE);
      if (places < 4) places++;
    endfunction

    function void take(logic [dsms_pkg::CharWidth-1:0] c);
      bit ok;
      ok = 0;
      if (err) return;
      case (phase)
        dsms_pkg::PH_LEAD: begin
          if (is_ws(c)) ok = 1;
          else if (is_digit(c)) begin
            phase = dsms_pkg::PH_INT;
            add_whole_digit(c - dsms_pkg::CHAR_ZERO);
            ok = 1;
          end
        end
        dsms_pkg::PH_INT: begin
          if (is_digit(c)) begin
            add_whole_digit(c - dsms_pkg::CHAR_ZERO);
            ok = 1;
          end else if (c == dsms_pkg::CHAR_DOT) begin
            phase = dsms_pkg::PH_DOT;
            ok = 1;
          end else if (is_ws(c)) begin
            phase = dsms_pkg::PH_TRAIL;
            ok = 1;
          end
        end
        dsms_pkg::PH_DOT: begin
          if (is_digit(c)) begin
            phase = dsms_pkg::PH_FRAC;
            add_frac_digit(c);
            ok = 1;
          end
        end
        dsms_pkg::PH_FRAC: begin
          if (is_digit(c)) begin
            add_frac_digit(c);
            ok = 1;
          end else if (is_ws(c)) begin
            phase = dsms_pkg::PH_TRAIL;
            ok = 1;
          end
        end
        dsms_pkg::PH_TRAIL: begin
          if (is_ws(c)) ok = 1;
        end
        default: ok = 0;
      endcase
      if (!ok) err = 1;
    endfunction

    // one accepted input transaction
    function void note_char(logic [dsms_pkg::CharWidth-1:0] c, logic last);
      ms_result_t r;
      bit bad;
      longint unsigned frac;
      take(c);
      if (!last) return;
      bad = err || phase == dsms_pkg::PH_LEAD || phase == dsms_pkg::PH_DOT;
      r.ms = '0;
      if (!bad) begin
        frac = frac_ms;
        for (int p = places; p < 3; p++) frac = frac * 10;
        if (whole > (MsMax - frac - rnd) / 1000) bad = 1;
        else r.ms = dsms_pkg::MsWidth'(whole * 1000 + frac + rnd);
      end
      r.status = bad;
      expected_ms.push_back(r);
      clear();
    endfunction

    // one accepted output transaction
    function void check_result(logic status, logic [dsms_pkg::MsWidth-1:0] ms);
      ms_result_t r;
      if (expected_ms.size() == 0) begin
        $error("unexpected result: status %0d, milliseconds %0d", status, ms);
        errors++;
        return;
      end
      r = expected_ms.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (ms !== r.ms) begin
        $error("milliseconds: expected %0d, actual %0d", r.ms, ms);
        errors++;
      end
    endfunction
  endclass

  ms_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.status, out_ch.milliseconds);
  end

  function automatic void push_text(string t);
    foreach (t[i]) str.push_back(t[i]);
  endfunction

  function automatic void push_ws(int unsigned n);
    int unsigned k;
    repeat (n) begin
      k = $urandom_range(0, 5);
      str.push_back((k == 5) ? dsms_pkg::CHAR_SPACE :
                    dsms_pkg::CHAR_TAB + dsms_pkg::CharWidth'(k));
    end
  endfunction

  function automatic void push_digits(int unsigned n);
    repeat (n) str.push_back(dsms_pkg::CHAR_ZERO + dsms_pkg::CharWidth'($urandom_range(0, 9)));
  endfunction

  function automatic void build_random();
    int unsigned kind;
    int unsigned shape;
    int unsigned n;
    str.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) str.push_back(dsms_pkg::CharWidth'($urandom_range(0, 255)));
      return;
    end
    push_ws($urandom_range(0, 2));
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1: begin
        // around the largest whole-seconds value
        push_text("922337203685477");
        push_digits(1);
      end
      2: push_digits($urandom_range(17, 19));
      3: begin
        repeat ($urandom_range(1, 3)) str.push_back(dsms_pkg::CHAR_ZERO);
        push_digits($urandom_range(1, 3));
      end
      default: push_digits($urandom_range(1, 4));
    endcase
    if ($urandom_range(0, 2) != 0) begin
      str.push_back(dsms_pkg::CHAR_DOT);
      if (shape < 2) begin
        case ($urandom_range(0, 5))
          0: push_text("807");
          1: push_text("808");
          2: push_text("8074");
          3: push_text("8075");
          4: push_text("999");
          default: push_text("0");
        endcase
      end else begin
        push_digits($urandom_range(1, 6));
      end
    end
    push_ws($urandom_range(0, 2));
    if (kind < 25) begin
      if ($urandom_range(0, 1) != 0) begin
        str[$urandom_range(0, str.size() - 1)] = dsms_pkg::CharWidth'($urandom_range(0, 255));
      end else begin
        n = $urandom_range(1, str.size());
        while (str.size() > n) void'(str.pop_back());
      end
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_char(logic [dsms_pkg::CharWidth-1:0] c, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string();
    foreach (str[i]) send_char(str[i], i == str.size() - 1);
    str.delete();
  endtask

  initial begin
    int unsigned send_pcts[3];
    int unsigned recv_pcts[3];
    sb = new();
    send_pcts = '{31, 73, 0};
    recv_pcts = '{73, 31, 0};
    send_idle_pct = send_pcts[0];
    recv_idle_pct = recv_pcts[0];
    chars_sent = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_text("0");
    send_string();
    str.push_back(8'd0);
    send_string();
    str.push_back(8'hFF);
    send_string();
    str.push_back(dsms_pkg::CHAR_SPACE);
    send_string();
    push_text("1.");
    send_string();
    push_text(".5");
    send_string();
    str.push_back(dsms_pkg::CHAR_CR);
    push_text("2.0005 ");
    send_string();
    push_text("3 4");
    send_string();
    push_text("1.2x");
    send_string();

    for (int k = 0; k < 3; k++) begin
      send_idle_pct = send_pcts[k];
      recv_idle_pct = recv_pcts[k];
      chars_sent = 0;
      while (chars_sent < CharsPerPhase) begin
        build_random();
        send_string();
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_ms.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
